// ===== src/ter_pkg.sv =====
`timescale 1ns / 1ps

package ter_pkg;

  // Fixed field widths.
  localparam int COORD_BITS = 16;
  localparam int FRAME_BITS = 13;
  localparam int PIX_BITS   = 12;
  localparam int COLOR_BITS = 32;
  localparam int CFG_IDX_W  = 2;

  // Box limits hold vertex coordinates and the frame size (up to 4096).
  localparam int BOX_W = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 1;
  // Edge coefficients a and b are coordinate differences.
  localparam int COEF_W = COORD_BITS + 1;
  // Multiplier operand that is a box limit minus a vertex coordinate.
  localparam int OPD_W = BOX_W + 1;
  // Product and doubled edge value widths.
  localparam int PROD_W = COEF_W + OPD_W;
  localparam int EDGE_W = PROD_W + 3;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX   = FRAME_BITS'(4096);
  localparam logic [FRAME_BITS-1:0] FRAME_W_RST = FRAME_BITS'(640);
  localparam logic [FRAME_BITS-1:0] FRAME_H_RST = FRAME_BITS'(480);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Request modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Setup product pair that forms the signed triangle area; pairs 1..3 are the edges.
  localparam logic [1:0] PAIR_AREA = 2'd0;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [BOX_W-1:0]      box_t;
  typedef logic signed [OPD_W-1:0]      opd_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic [FRAME_BITS-1:0]        frame_t;

  typedef struct packed {
    logic                  mode;
    coord_t                vert0_x;
    coord_t                vert0_y;
    coord_t                vert1_x;
    coord_t                vert1_y;
    coord_t                vert2_x;
    coord_t                vert2_y;
    logic [COLOR_BITS-1:0] fill_color;
  } cmd_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]   pixel_x;
    logic [PIX_BITS-1:0]   pixel_y;
    logic                  covered;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } pix_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_vert;
    logic       setup;
    logic       op_en;
    logic [1:0] op_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic box_empty;
    logic last;
  } dp_status_t;

endpackage

// ===== src/ter_ctrl.sv =====
`timescale 1ns / 1ps

module ter_ctrl
  import ter_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_mode,
  output logic       cmd_stall,
  output logic       pix_valid,
  input  logic       pix_stall,
  output dp_cmd_t    dp_cmd,
  input  dp_status_t dp_status
);

  // Four operand pairs, then the operand and product registers before the last sum is written.
  localparam int MUL_OPS  = 4;
  localparam int ACC_LAT  = 2;
  localparam int CNT_W    = $clog2(MUL_OPS + ACC_LAT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_OPS + ACC_LAT - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             pix_valid_next;
  logic             accept;

  // New requests wait during setup and while a result is held.
  assign cmd_stall = (state == ST_LOAD) || (state == ST_MUL) || (pix_valid && pix_stall);
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pix_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pix_valid <= pix_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    dp_cmd         = '0;
    unique case (state) inside
      ST_IDLE, ST_RUN: begin
        if (accept && (cmd_mode == MODE_START)) begin
          dp_cmd.load_vert = 1'b1;
          state_next       = ST_LOAD;
        end else if (accept && (state == ST_RUN)) begin
          dp_cmd.step = 1'b1;
          if (dp_status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        dp_cmd.setup = 1'b1;
        cnt_next     = '0;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        dp_cmd.op_en   = (cnt < CNT_W'(MUL_OPS));
        dp_cmd.op_sel  = cnt[1:0];
        dp_cmd.acc_en  = (cnt >= CNT_W'(ACC_LAT));
        dp_cmd.acc_sel = 2'(cnt - CNT_W'(ACC_LAT));
        cnt_next       = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = dp_status.box_empty ? ST_IDLE : ST_RUN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    pix_valid_next = dp_cmd.step || (pix_valid && pix_stall);
  end

endmodule

// ===== src/ter_datapath.sv =====
`timescale 1ns / 1ps

module ter_datapath
  import ter_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_item_t            cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  frame_t               cfg_data,
  input  dp_cmd_t              dp_cmd,
  output dp_status_t           dp_status,
  output pix_item_t            pix
);

  frame_t                frame_width;
  frame_t                frame_height;
  coord_t                vx [3];
  coord_t                vy [3];
  logic [COLOR_BITS-1:0] held_color;
  coef_t                 edge_a [3];
  coef_t                 edge_b [3];
  edge_t                 row_val [3];
  edge_t                 pix_val [3];
  box_t                  box_left;
  box_t                  box_right;
  box_t                  box_top;
  box_t                  box_bottom;
  box_t                  cur_col;
  box_t                  cur_row;
  coef_t                 op_a0;
  opd_t                  op_d0;
  coef_t                 op_a1;
  opd_t                  op_d1;
  prod_t                 prod0;
  prod_t                 prod1;
  logic                  d_neg;

  coord_t                lo_x;
  coord_t                hi_x;
  coord_t                lo_y;
  coord_t                hi_y;
  box_t                  w_lim;
  box_t                  h_lim;
  box_t                  left_c;
  box_t                  top_c;
  box_t                  right_c;
  box_t                  bottom_c;
  logic [1:0]            op_idx;
  logic [1:0]            acc_idx;
  edge_t                 prod_sum;
  edge_t                 edge_sum;
  edge_t                 edge_val;
  logic                  covered;

  // Bounding box of the vertices, clipped to the frame.
  always_comb begin
    lo_x = vx[0];
    hi_x = vx[0];
    lo_y = vy[0];
    hi_y = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < lo_x) lo_x = vx[i];
      if (vx[i] > hi_x) hi_x = vx[i];
      if (vy[i] < lo_y) lo_y = vy[i];
      if (vy[i] > hi_y) hi_y = vy[i];
    end
    w_lim    = box_t'($signed({1'b0, (frame_width > FRAME_MAX) ? FRAME_MAX : frame_width}));
    h_lim    = box_t'($signed({1'b0, (frame_height > FRAME_MAX) ? FRAME_MAX : frame_height}));
    left_c   = (lo_x < 0) ? '0 : box_t'(lo_x);
    top_c    = (lo_y < 0) ? '0 : box_t'(lo_y);
    right_c  = ((box_t'(hi_x) > w_lim) ? w_lim : box_t'(hi_x)) - box_t'(1);
    bottom_c = ((box_t'(hi_y) > h_lim) ? h_lim : box_t'(hi_y)) - box_t'(1);
  end

  // Edge sums: pair indexes 1..3 map to edges 0..2.
  assign op_idx   = dp_cmd.op_sel - 2'd1;
  assign acc_idx  = dp_cmd.acc_sel - 2'd1;
  assign prod_sum = edge_t'(prod0) + edge_t'(prod1);
  assign edge_sum = (prod_sum <<< 1) + edge_t'(edge_a[acc_idx]) + edge_t'(edge_b[acc_idx]);
  assign edge_val = d_neg ? -edge_sum : edge_sum;

  assign covered = !pix_val[0][EDGE_W-1] && !pix_val[1][EDGE_W-1] && !pix_val[2][EDGE_W-1];

  assign dp_status.box_empty = (box_left > box_right) || (box_top > box_bottom);
  assign dp_status.last      = (cur_col == box_right) && (cur_row == box_bottom);

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_W_RST;
      frame_height <= FRAME_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Vertex capture and edge coefficients.
  always_ff @(posedge clk) begin
    if (dp_cmd.load_vert) begin
      vx[0]      <= cmd.vert0_x;
      vy[0]      <= cmd.vert0_y;
      vx[1]      <= cmd.vert1_x;
      vy[1]      <= cmd.vert1_y;
      vx[2]      <= cmd.vert2_x;
      vy[2]      <= cmd.vert2_y;
      held_color <= cmd.fill_color;
    end
    if (dp_cmd.setup) begin
      for (int i = 0; i < 3; i++) begin
        edge_a[i] <= coef_t'(vy[(i + 1) % 3]) - coef_t'(vy[i]);
        edge_b[i] <= coef_t'(vx[i]) - coef_t'(vx[(i + 1) % 3]);
      end
    end else if (dp_cmd.acc_en && (dp_cmd.acc_sel != PAIR_AREA)) begin
      // Orient the edge so the inside is on its non-negative side.
      for (int i = 0; i < 3; i++) begin
        if (acc_idx == 2'(i) && d_neg) begin
          edge_a[i] <= -edge_a[i];
          edge_b[i] <= -edge_b[i];
        end
      end
    end
  end

  // Operand stage, then the product registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.op_en) begin
      if (dp_cmd.op_sel == PAIR_AREA) begin
        op_a0 <= edge_a[0];
        op_d0 <= opd_t'(vx[2]) - opd_t'(vx[0]);
        op_a1 <= edge_b[0];
        op_d1 <= opd_t'(vy[2]) - opd_t'(vy[0]);
      end else begin
        op_a0 <= edge_a[op_idx];
        op_d0 <= opd_t'(box_left) - opd_t'(vx[op_idx]);
        op_a1 <= edge_b[op_idx];
        op_d1 <= opd_t'(box_top) - opd_t'(vy[op_idx]);
      end
    end
    prod0 <= op_a0 * op_d0;
    prod1 <= op_a1 * op_d1;
  end

  // Area sign decides whether every edge is negated.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_neg <= 1'b0;
    end else if (dp_cmd.acc_en && (dp_cmd.acc_sel == PAIR_AREA)) begin
      d_neg <= prod_sum[EDGE_W-1];
    end
  end

  // Box, cursor and edge values: set up on start, stepped per pixel.
  always_ff @(posedge clk) begin
    if (dp_cmd.setup) begin
      box_left   <= left_c;
      box_right  <= right_c;
      box_top    <= top_c;
      box_bottom <= bottom_c;
      cur_col    <= left_c;
      cur_row    <= top_c;
    end else if (dp_cmd.acc_en && (dp_cmd.acc_sel != PAIR_AREA)) begin
      for (int i = 0; i < 3; i++) begin
        if (acc_idx == 2'(i)) begin
          row_val[i] <= edge_val;
          pix_val[i] <= edge_val;
        end
      end
    end else if (dp_cmd.step && !dp_status.last) begin
      if (cur_col < box_right) begin
        cur_col <= cur_col + box_t'(1);
        for (int i = 0; i < 3; i++) begin
          pix_val[i] <= pix_val[i] + (edge_t'(edge_a[i]) <<< 1);
        end
      end else begin
        cur_col <= box_left;
        cur_row <= cur_row + box_t'(1);
        for (int i = 0; i < 3; i++) begin
          row_val[i] <= row_val[i] + (edge_t'(edge_b[i]) <<< 1);
          pix_val[i] <= row_val[i] + (edge_t'(edge_b[i]) <<< 1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (dp_cmd.step) begin
      pix.pixel_x     <= cur_col[PIX_BITS-1:0];
      pix.pixel_y     <= cur_row[PIX_BITS-1:0];
      pix.covered     <= covered;
      pix.pixel_color <= held_color;
      pix.last_pixel  <= dp_status.last;
    end
  end

endmodule

// ===== src/triangle_edge_function_raster.sv =====
`timescale 1ns / 1ps

// Flat-colored triangle rasterizer using edge functions. A start request
// loads three vertices and a color; setup then runs in a load state (the
// clipped bounding box and edge coefficients) and a multiply state (a shared
// pair of multipliers forms the triangle area sign and the doubled edge
// values at the first box pixel), with cmd_stall high. Each step request
// then visits one box pixel in raster order and returns its coordinates, a
// covered flag, the color and a last mark, one pixel per cycle while
// pix_stall stays low. Pixels are sampled at their centers. Step requests
// with no triangle loaded give no result. The user must write the frame size
// registers (0: width, 1: height) only while idle; it is not enforced.

module triangle_edge_function_raster
  import ter_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_item_t            cmd,
  output logic                 pix_valid,
  input  logic                 pix_stall,
  output pix_item_t            pix,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  frame_t               cfg_data
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  ter_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_mode  (cmd.mode),
    .cmd_stall (cmd_stall),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  ter_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .pix       (pix)
  );

endmodule

// ===== src/ter_checker.sv =====
`timescale 1ns / 1ps

module ter_checker
  import ter_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_stall,
  input cmd_item_t            cmd,
  input logic                 pix_valid,
  input logic                 pix_stall,
  input pix_item_t            pix,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  logic start_acc;

  assign start_acc = cmd_valid && !cmd_stall && (cmd.mode == MODE_START);

  // A held result stays valid and unchanged.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix))
    else $error("result changed while stalled");

  // Setup follows a start, so the next request must wait.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> cmd_stall)
    else $error("request taken during setup");

  // A start request never produces a result.
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    start_acc && !(pix_valid && pix_stall) |=> !pix_valid)
    else $error("result produced by a start request");

  // Frame size writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind triangle_edge_function_raster ter_checker u_ter_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ter_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int SETUP_WAIT   = 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam int PHASES       = 7;

  // Indexes past the two frame registers; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  // Tracks the rasterizer walk and holds the pixels still owed by the block.
  class pixel_walk_tracker;
    longint step_x[3];
    longint step_y[3];
    longint row_val[3];
    longint pix_val[3];
    longint col, row, left, right, bottom;
    bit active;
    logic [COLOR_BITS-1:0] color;
    int frame_w, frame_h;
    pix_item_t pending_pixels[$];
    int mismatch_count;

    function new();
      frame_w = 640;
      frame_h = 480;
      color = '0;
      active = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_frame(logic [CFG_IDX_W-1:0] idx, frame_t data);
      if (idx == REG_FRAME_WIDTH) begin
        frame_w = int'(data);
      end else if (idx == REG_FRAME_HEIGHT) begin
        frame_h = int'(data);
      end
    endfunction

    // Pixels left in the box walk, counting the one at the cursor.
    function longint pixels_left();
      if (!active) return 0;
      return (right - col + 1) + (bottom - row) * (right - left + 1);
    endfunction

    // Apply one accepted request: a start loads a triangle, a step owes a pixel.
    function void take_request(cmd_item_t it);
      longint vx[3];
      longint vy[3];
      longint lo_x, hi_x, lo_y, hi_y, top, a, b, c, lim_w, lim_h;
      int i, j, k;
      pix_item_t px;
      if (it.mode == MODE_START) begin
        vx[0] = coord_t'(it.vert0_x);
        vy[0] = coord_t'(it.vert0_y);
        vx[1] = coord_t'(it.vert1_x);
        vy[1] = coord_t'(it.vert1_y);
        vx[2] = coord_t'(it.vert2_x);
        vy[2] = coord_t'(it.vert2_y);
        color = it.fill_color;
        lo_x = vx[0];
        hi_x = vx[0];
        lo_y = vy[0];
        hi_y = vy[0];
        for (i = 1; i < 3; i++) begin
          if (vx[i] < lo_x) lo_x = vx[i];
          if (vx[i] > hi_x) hi_x = vx[i];
          if (vy[i] < lo_y) lo_y = vy[i];
          if (vy[i] > hi_y) hi_y = vy[i];
        end
        // Clip to the frame; sizes above 4096 saturate.
        lim_w = (frame_w > 4096) ? 4096 : frame_w;
        lim_h = (frame_h > 4096) ? 4096 : frame_h;
        if (lo_x < 0) lo_x = 0;
        if (lo_y < 0) lo_y = 0;
        if (hi_x > lim_w) hi_x = lim_w;
        if (hi_y > lim_h) hi_y = lim_h;
        left = lo_x;
        right = hi_x - 1;
        top = lo_y;
        bottom = hi_y - 1;
        // Orient each edge so the opposite vertex is on the non-negative side.
        for (i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          a = vy[j] - vy[i];
          b = vx[i] - vx[j];
          c = vx[j] * vy[i] - vx[i] * vy[j];
          if (a * vx[k] + b * vy[k] + c < 0) begin
            a = -a;
            b = -b;
            c = -c;
          end
          step_x[i] = a;
          step_y[i] = b;
          row_val[i] = 2 * a * left + 2 * b * top + 2 * c + a + b;
          pix_val[i] = row_val[i];
        end
        col = left;
        row = top;
        active = (left <= right) && (top <= bottom);
      end else if (active) begin
        px.pixel_x = PIX_BITS'(col);
        px.pixel_y = PIX_BITS'(row);
        px.covered = (pix_val[0] >= 0) && (pix_val[1] >= 0) && (pix_val[2] >= 0);
        px.pixel_color = color;
        px.last_pixel = (col == right) && (row == bottom);
        pending_pixels.push_back(px);
        // Advance the cursor in raster order.
        if (px.last_pixel) begin
          active = 1'b0;
        end else if (col < right) begin
          col++;
          for (i = 0; i < 3; i++) pix_val[i] += 2 * step_x[i];
        end else begin
          col = left;
          row++;
          for (i = 0; i < 3; i++) begin
            row_val[i] += 2 * step_y[i];
            pix_val[i] = row_val[i];
          end
        end
      end
    endfunction

    // Compare one returned pixel with the oldest one owed.
    function void check_pixel(pix_item_t got);
      pix_item_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel (%0d,%0d) returned, expected none, no step request pending",
                 $time, got.pixel_x, got.pixel_y);
        mismatch_count++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $display("%0t: pixel_x expected %0d, actual %0d", $time, want.pixel_x, got.pixel_x);
        mismatch_count++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $display("%0t: pixel_y expected %0d, actual %0d", $time, want.pixel_y, got.pixel_y);
        mismatch_count++;
      end
      if (got.covered !== want.covered) begin
        $display("%0t: covered at (%0d,%0d) expected %0b, actual %0b", $time,
                 want.pixel_x, want.pixel_y, want.covered, got.covered);
        mismatch_count++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $display("%0t: pixel_color expected %h, actual %h", $time,
                 want.pixel_color, got.pixel_color);
        mismatch_count++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $display("%0t: last_pixel at (%0d,%0d) expected %0b, actual %0b", $time,
                 want.pixel_x, want.pixel_y, want.last_pixel, got.last_pixel);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_item_t            cmd = '0;
  logic                 pix_valid;
  logic                 pix_stall = 1'b0;
  pix_item_t            pix;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  frame_t               cfg_data = '0;

  pixel_walk_tracker tracker = new();
  int cycle_count = 0;
  int items_sent = 0;
  bit cmd_eager = 1'b0;
  bit pix_eager = 1'b0;
  int pix_hold = 0;
  int phase_w[PHASES] = '{1, 4096, 0, 8191, 24, 13, 640};
  int phase_h[PHASES] = '{1, 4096, 7, 20, 4096, 0, 480};

  triangle_edge_function_raster DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d pixels outstanding", $time,
               tracker.pending_pixels.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Pixel receiver: checks each accepted pixel, then stalls at random.
  initial begin : pixel_sink
    pix_item_t seen;
    bit got;
    forever begin
      @(posedge clk);
      got = !rst && (pix_valid === 1'b1) && !pix_stall;
      seen = pix;
      if (got) begin
        if ($urandom_range(0, 31) == 0) pix_eager = !pix_eager;
        pix_hold = pix_eager ? 0 : $urandom_range(0, 4);
      end
      #1;
      if (got) tracker.check_pixel(seen);
      @(negedge clk);
      pix_stall <= (pix_hold > 0);
      if (pix_hold > 0) pix_hold--;
    end
  end

  function automatic cmd_item_t start_item(int x0, int y0, int x1, int y1, int x2, int y2,
                                           logic [COLOR_BITS-1:0] fill);
    cmd_item_t it;
    it.mode = MODE_START;
    it.vert0_x = coord_t'(x0);
    it.vert0_y = coord_t'(y0);
    it.vert1_x = coord_t'(x1);
    it.vert1_y = coord_t'(y1);
    it.vert2_x = coord_t'(x2);
    it.vert2_y = coord_t'(y2);
    it.fill_color = fill;
    return it;
  endfunction

  // A step request; the vertex and color fields carry noise that must be ignored.
  function automatic cmd_item_t step_item();
    cmd_item_t it;
    it = start_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.mode = MODE_STEP;
    return it;
  endfunction

  // Coordinate biased toward the low and high borders of a frame dimension.
  function automatic int near_border(int lim);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 10)) - 8;
      1: return lim - 8 + int'($urandom_range(0, 10));
      default: return int'($urandom_range(0, lim + 4)) - 4;
    endcase
  endfunction

  task automatic push_request(input cmd_item_t it);
    int gap;
    gap = cmd_eager ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    tracker.take_request(it);
  endtask

  task automatic push_steps(input longint n);
    repeat (n) push_request(step_item());
  endtask

  // Hold off requests until every owed pixel is back and setup has finished.
  task automatic wait_for_pixels();
    @(negedge clk) cmd_valid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETUP_WAIT) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input frame_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_frame(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // One start request followed by the steps that walk (most of) its box.
  task automatic run_triangle();
    int lim_w, lim_h, bx, by, d, e, span, kind;
    longint n;
    lim_w = (tracker.frame_w > 4096) ? 4096 : tracker.frame_w;
    lim_h = (tracker.frame_h > 4096) ? 4096 : tracker.frame_h;
    cmd_eager = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // Full-range vertices; the box is usually huge, so walk only a little.
      push_request(start_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
      n = $urandom_range(0, 12);
    end else begin
      bx = near_border(lim_w);
      by = near_border(lim_h);
      if (kind == 1) begin
        // Collinear vertices.
        d = $urandom_range(0, 3);
        e = $urandom_range(0, 3);
        push_request(start_item(bx + 2 * d, by + 2 * e, bx, by, bx + d, by + e, $urandom));
      end else begin
        span = (kind == 2) ? 14 : 7;
        push_request(start_item(bx + $urandom_range(0, span), by + $urandom_range(0, span),
                                bx + $urandom_range(0, span), by + $urandom_range(0, span),
                                bx + $urandom_range(0, span), by + $urandom_range(0, span),
                                $urandom));
      end
      n = tracker.pixels_left();
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(0, n);
      end else if ($urandom_range(0, 3) == 0) begin
        n = n + 1;
      end
    end
    items_sent += 1 + int'(n);
    push_steps(n);
    if ($urandom_range(0, 19) == 0) wait_for_pixels();
  endtask

  initial begin : stimulus
    int p;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed requests at the reset frame size of 640 by 480.
    push_request(step_item());
    push_request(start_item(-32768, -32768, 32767, -32768, -32768, 32767, 32'hFFFF_FFFF));
    push_steps(2);
    push_request(start_item(0, 0, 2, 2, 1, 1, 32'h0000_0000));
    push_steps(4);
    push_request(start_item(5, 5, 5, 5, 5, 5, 32'h1234_5678));
    push_request(step_item());
    push_request(start_item(10, 10, 12, 10, 10, 12, 32'hA5A5_A5A5));
    push_steps(4);
    push_request(start_item(10, 10, 10, 12, 12, 10, 32'h5A5A_5A5A));
    push_steps(4);
    push_request(start_item(638, 478, 645, 478, 638, 490, 32'h0F0F_F0F0));
    push_steps(5);

    // Random triangles under a series of frame sizes.
    for (p = 0; p < PHASES; p++) begin
      push_request(start_item(3, 3, 3, 3, 3, 3, $urandom));
      wait_for_pixels();
      if (p == 3) begin
        write_register(REG_SPARE_LO, frame_t'($urandom));
        write_register(REG_SPARE_HI, frame_t'($urandom));
      end
      write_register(REG_FRAME_WIDTH, frame_t'(phase_w[p]));
      write_register(REG_FRAME_HEIGHT, frame_t'(phase_h[p]));
      while (items_sent < (p + 1) * RANDOM_ITEMS / PHASES) run_triangle();
    end

    wait_for_pixels();
    if (tracker.mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
